// File: rtl/siread_lock_table_top_macros.svh
// ----------------------------------------------------------------------------
// siread lock table assertion macros
// shared assertion forms for the lock table top level
// ----------------------------------------------------------------------------
`ifndef SIREAD_LOCK_TABLE_TOP_MACROS_SVH
`define SIREAD_LOCK_TABLE_TOP_MACROS_SVH

// implication checked on every edge outside reset
`define SLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication outside reset
`define SLT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// types and constants for the siread lock table
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_HOLDERS = 2'd1;
    localparam logic [1:0] OP_FINISH  = 2'd2;
    localparam logic [1:0] OP_GC      = 2'd3;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_HELD  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] txn_id;
        logic [31:0] page_id;
        logic [47:0] time_stamp;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] holder_txn;
        logic        holder_found;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [31:0] txn;
        logic [31:0] page;
        logic [47:0] finish;
    } t_rec;

    // per-cycle command broadcast to all cells
    typedef struct packed {
        logic        append;
        logic        finish;
        logic        gc_step;
        logic        rotate;
        logic [31:0] txn;
        logic [31:0] page;
        logic [47:0] stamp;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOLD,
        S_GC,
        S_OUT
    } t_state;

endpackage

// File: rtl/slt_cell.sv
// ----------------------------------------------------------------------------
// slt_cell
// one record slot of the table chain with local match logic
// ----------------------------------------------------------------------------
module slt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slt_pkg::t_cell_cmd i_cmd,
    input  logic              i_is_tail,
    input  slt_pkg::t_rec     i_from_next,
    input  logic              i_prev_drop,
    output slt_pkg::t_rec     o_rec,
    output logic              o_drop,
    output logic              o_pair_hit,
    output logic              o_page_hit
);

    slt_pkg::t_rec r_rec;
    slt_pkg::t_rec n_rec;
    logic          w_drop_me;

    assign w_drop_me  = r_rec.valid && (r_rec.finish != '0)
                        && (r_rec.finish < i_cmd.stamp);
    assign o_drop     = i_prev_drop || w_drop_me;
    assign o_rec      = r_rec;
    assign o_pair_hit = r_rec.valid && r_rec.txn == i_cmd.txn && r_rec.page == i_cmd.page;
    assign o_page_hit = r_rec.valid && r_rec.page == i_cmd.page;

    always_comb begin
        n_rec = r_rec;
        if (i_cmd.append && i_is_tail) begin
            n_rec.valid  = 1'b1;
            n_rec.txn    = i_cmd.txn;
            n_rec.page   = i_cmd.page;
            n_rec.finish = '0;
        end else if (i_cmd.finish) begin
            if (r_rec.valid && r_rec.txn == i_cmd.txn) begin
                n_rec.finish = i_cmd.stamp;
            end
        end else if (i_cmd.gc_step || i_cmd.rotate) begin
            // gc shifts left by one from the first dropped slot on, rotate shifts every slot
            if (i_cmd.rotate || o_drop) begin
                n_rec = i_from_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.valid <= 1'b0;
        end else begin
            r_rec.valid <= n_rec.valid;
        end
        r_rec.txn    <= n_rec.txn;
        r_rec.page   <= n_rec.page;
        r_rec.finish <= n_rec.finish;
    end

endmodule

// File: rtl/siread_lock_table_top.sv
// ----------------------------------------------------------------------------
// siread_lock_table_top
// read-lock record table kept as a chain of record cells
// ----------------------------------------------------------------------------
// channel  direction  payload
// in       input      opcode, txn_id, page_id, time_stamp
// out      output     status, holder_txn, holder_found, last
// acquire and finish complete in idle, the acquire result follows in the next cycle
// holders: rotates the chain through all ENTRIES records, the last result goes out after
// gc: removes one record per step until none is left to drop, removal shifts the chain
// a match that finds the previous one still on out holds the rotation
// reset clears valid bits, state and counters only
// ----------------------------------------------------------------------------
`include "siread_lock_table_top_macros.svh"

module siread_lock_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  slt_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output slt_pkg::t_out_item o_item
);

    localparam int N = slt_pkg::ENTRIES;

    slt_pkg::t_state    r_state, n_state;
    slt_pkg::t_in_item  r_in;
    slt_pkg::t_out_item r_out, n_out;
    logic               r_out_v, n_out_v;
    logic [slt_pkg::IDX_W-1:0] r_cnt, n_cnt;
    logic               r_found, n_found;
    logic               r_pend, n_pend;
    slt_pkg::t_out_item r_pend_item, n_pend_item;
    logic [slt_pkg::CNT_W-1:0] r_count, n_count;

    slt_pkg::t_cell_cmd w_cmd;
    slt_pkg::t_rec      w_rec  [N];
    logic               w_drop [N+1];
    logic [N-1:0]       w_pair, w_tail_v;
    logic               w_accept, w_out_free, w_any_drop, w_head_hit;
    logic               w_hold_go;
    slt_pkg::t_rec      w_empty;

    assign w_empty    = '0;
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_v || i_ready;
    assign w_drop[0]  = 1'b0;
    assign w_any_drop = w_drop[N];
    assign w_hold_go  = !r_pend && !(w_head_hit && r_found && !w_out_free);

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic w_page;
            assign w_tail_v[g] = (r_count == slt_pkg::CNT_W'(g));
            slt_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_is_tail   (w_tail_v[g]),
                .i_from_next ((g == N - 1) ? (w_cmd.rotate ? w_rec[0] : w_empty)
                                           : w_rec[(g + 1) % N]),
                .i_prev_drop (w_drop[g]),
                .o_rec       (w_rec[g]),
                .o_drop      (w_drop[g+1]),
                .o_pair_hit  (w_pair[g]),
                .o_page_hit  (w_page)
            );
            if (g == 0) begin : g_head
                assign w_head_hit = w_page;
            end
        end
    endgenerate

    assign o_ready = (r_state == slt_pkg::S_IDLE) && w_out_free && !r_pend;
    assign o_valid = r_out_v;
    assign o_item  = r_out;

    // command to cells
    always_comb begin
        w_cmd         = '0;
        w_cmd.txn     = w_accept ? i_item.txn_id  : r_in.txn_id;
        w_cmd.page    = w_accept ? i_item.page_id : r_in.page_id;
        w_cmd.stamp   = w_accept ? i_item.time_stamp : r_in.time_stamp;
        if (w_accept) begin
            w_cmd.append = (i_item.opcode == slt_pkg::OP_ACQUIRE) && (w_pair == '0)
                           && (r_count < slt_pkg::CNT_W'(N));
            w_cmd.finish = (i_item.opcode == slt_pkg::OP_FINISH);
        end
        if (r_state == slt_pkg::S_GC) begin
            w_cmd.gc_step = 1'b1;
        end
        if (r_state == slt_pkg::S_HOLD && w_hold_go) begin
            w_cmd.rotate = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slt_pkg::S_IDLE: begin
                if (w_accept && i_item.opcode == slt_pkg::OP_HOLDERS) begin
                    n_state = slt_pkg::S_HOLD;
                end else if (w_accept && i_item.opcode == slt_pkg::OP_GC) begin
                    n_state = slt_pkg::S_GC;
                end
            end
            slt_pkg::S_HOLD: begin
                if (w_hold_go && r_cnt == slt_pkg::IDX_W'(N - 1)) begin
                    n_state = slt_pkg::S_OUT;
                end
            end
            slt_pkg::S_GC: begin
                if (!w_any_drop) begin
                    n_state = slt_pkg::S_IDLE;
                end
            end
            slt_pkg::S_OUT: begin
                if (!r_pend) begin
                    n_state = slt_pkg::S_IDLE;
                end
            end
            default: n_state = slt_pkg::S_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        n_out       = r_out;
        n_out_v     = r_out_v && !i_ready;
        n_cnt       = r_cnt;
        n_found     = r_found;
        n_pend      = r_pend;
        n_pend_item = r_pend_item;
        n_count     = r_count;

        if (r_pend && w_out_free) begin
            n_out   = r_pend_item;
            n_out_v = 1'b1;
            n_pend  = 1'b0;
        end

        case (r_state)
            slt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cnt   = '0;
                    n_found = 1'b0;
                    if (i_item.opcode == slt_pkg::OP_ACQUIRE) begin
                        n_out_v = 1'b1;
                        n_out   = '0;
                        n_out.last = 1'b1;
                        if (w_pair != '0) begin
                            n_out.status = slt_pkg::ST_HELD;
                        end else if (r_count >= slt_pkg::CNT_W'(N)) begin
                            n_out.status = slt_pkg::ST_FULL;
                        end else begin
                            n_out.status = slt_pkg::ST_ADDED;
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end
            slt_pkg::S_HOLD: begin
                if (w_hold_go) begin
                    // head record leaves this cycle; the held match goes out on a new one
                    n_cnt = r_cnt + 1'b1;
                    if (w_head_hit) begin
                        if (r_found) begin
                            n_out   = r_pend_item;
                            n_out_v = 1'b1;
                        end
                        n_found = 1'b1;
                        n_pend_item              = '0;
                        n_pend_item.holder_txn   = w_rec[0].txn;
                        n_pend_item.holder_found = 1'b1;
                    end
                end
            end
            slt_pkg::S_GC: begin
                if (w_any_drop) begin
                    n_count = r_count - 1'b1;
                end
            end
            slt_pkg::S_OUT: begin
                if (!r_pend) begin
                    n_pend            = 1'b1;
                    n_pend_item       = r_found ? r_pend_item : '0;
                    n_pend_item.last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slt_pkg::S_IDLE;
            r_out_v <= 1'b0;
            r_pend  <= 1'b0;
            r_count <= '0;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_found <= n_found;
            r_cnt   <= n_cnt;
        end
        r_out       <= n_out;
        r_pend_item <= n_pend_item;
        if (w_accept) begin
            r_in <= i_item;
        end
    end

    `SLT_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1,
        r_count <= slt_pkg::CNT_W'(N), "record count above table size")
    `SLT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready,
        r_state == slt_pkg::S_IDLE, "ready outside idle")
    `SLT_ASSERT_NXT(a_gc_shrinks, i_clk, i_rst_n,
        r_state == slt_pkg::S_GC && w_any_drop, r_count == $past(r_count) - 1'b1,
        "gc step did not shrink table")

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// lock table testbench: directed and random acquire, holders, finish and gc items checked
// against an in-bench table model, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    slt_pkg::t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    slt_pkg::t_out_item o_item;

    siread_lock_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // table model
    logic [31:0] tbl_txn[slt_pkg::ENTRIES];
    logic [31:0] tbl_page[slt_pkg::ENTRIES];
    logic [47:0] tbl_fin[slt_pkg::ENTRIES];
    int          tbl_cnt = 0;

    slt_pkg::t_in_item  pending_items[$];
    slt_pkg::t_out_item lock_results[$];
    int        errors = 0;
    int        idle_cycles = 0;
    logic      drain_pause = 1'b0;
    logic      calm = 1'b0;
    logic      hold_rx = 1'b0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    logic      done = 1'b0;
    logic [31:0] txn_pool[8];
    logic [31:0] page_pool[8];

    function automatic slt_pkg::t_out_item mk(logic [1:0] st, logic [31:0] t, logic f,
                                              logic l);
        slt_pkg::t_out_item r;
        r.status = st;
        r.holder_txn = t;
        r.holder_found = f;
        r.last = l;
        return r;
    endfunction

    task automatic add_result(slt_pkg::t_out_item r);
        lock_results.insert(lock_results.size(), r);
    endtask

    task automatic add_item(slt_pkg::t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic apply_lock_op(slt_pkg::t_in_item it);
        int w;
        int n;
        logic hit;
        hit = 1'b0;
        case (it.opcode)
            slt_pkg::OP_ACQUIRE: begin
                for (int i = 0; i < tbl_cnt; i++)
                    if (tbl_txn[i] == it.txn_id && tbl_page[i] == it.page_id) hit = 1'b1;
                if (hit) begin
                    add_result(mk(slt_pkg::ST_HELD, '0, 1'b0, 1'b1));
                end else if (tbl_cnt >= slt_pkg::ENTRIES) begin
                    add_result(mk(slt_pkg::ST_FULL, '0, 1'b0, 1'b1));
                end else begin
                    tbl_txn[tbl_cnt] = it.txn_id;
                    tbl_page[tbl_cnt] = it.page_id;
                    tbl_fin[tbl_cnt] = '0;
                    tbl_cnt++;
                    add_result(mk(slt_pkg::ST_ADDED, '0, 1'b0, 1'b1));
                end
            end
            slt_pkg::OP_HOLDERS: begin
                n = 0;
                for (int i = 0; i < tbl_cnt; i++)
                    if (tbl_page[i] == it.page_id) begin
                        add_result(mk(slt_pkg::ST_ADDED, tbl_txn[i], 1'b1, 1'b0));
                        n++;
                    end
                if (n == 0) add_result(mk(slt_pkg::ST_ADDED, '0, 1'b0, 1'b1));
                else lock_results[$].last = 1'b1;
            end
            slt_pkg::OP_FINISH: begin
                for (int i = 0; i < tbl_cnt; i++)
                    if (tbl_txn[i] == it.txn_id) tbl_fin[i] = it.time_stamp;
            end
            default: begin
                w = 0;
                for (int i = 0; i < tbl_cnt; i++)
                    if (!(tbl_fin[i] != 0 && tbl_fin[i] < it.time_stamp)) begin
                        tbl_txn[w] = tbl_txn[i];
                        tbl_page[w] = tbl_page[i];
                        tbl_fin[w] = tbl_fin[i];
                        w++;
                    end
                tbl_cnt = w;
            end
        endcase
    endtask

    task automatic report(string what, slt_pkg::t_out_item got, slt_pkg::t_out_item want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic slt_pkg::t_in_item mk_in(logic [1:0] op, logic [31:0] t,
                                                logic [31:0] p, logic [47:0] ts);
        slt_pkg::t_in_item it;
        it.opcode = op;
        it.txn_id = t;
        it.page_id = p;
        it.time_stamp = ts;
        return it;
    endfunction

    function automatic logic [47:0] rnd48();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_valid && o_ready) apply_lock_op(i_item);
        if (i_rst_n && (!i_valid || o_ready)) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0 && !drain_pause) begin
                i_item <= pending_items.pop_front();
                i_valid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 14);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        slt_pkg::t_out_item want;
        if (o_valid && i_ready) begin
            if (lock_results.size() == 0) begin
                report("unexpected item", o_item, '0);
            end else begin
                want = lock_results.pop_front();
                if (o_item.status !== want.status) report("status", o_item, want);
                if (o_item.holder_txn !== want.holder_txn) report("holder_txn", o_item, want);
                if (o_item.holder_found !== want.holder_found)
                    report("holder_found", o_item, want);
                if (o_item.last !== want.last) report("last", o_item, want);
            end
        end
        if (!i_rst_n || hold_rx) begin
            i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 14);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        slt_pkg::t_in_item it;
        int k;
        for (int i = 0; i < 8; i++) begin
            txn_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom();
            page_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom();
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed part
        add_item(mk_in(slt_pkg::OP_HOLDERS, 0, 0, 0));
        add_item(mk_in(slt_pkg::OP_ACQUIRE, 0, 0, 0));
        add_item(mk_in(slt_pkg::OP_ACQUIRE, 0, 0, 0));
        add_item(mk_in(slt_pkg::OP_ACQUIRE, '1, '1, '1));
        add_item(mk_in(slt_pkg::OP_ACQUIRE, 5, '1, 0));
        add_item(mk_in(slt_pkg::OP_HOLDERS, 0, '1, 0));
        add_item(mk_in(slt_pkg::OP_FINISH, 77, 0, 9));
        add_item(mk_in(slt_pkg::OP_FINISH, '1, 0, '1));
        add_item(mk_in(slt_pkg::OP_ACQUIRE, '1, '1, 0));
        add_item(mk_in(slt_pkg::OP_FINISH, 5, 0, 10));
        add_item(mk_in(slt_pkg::OP_FINISH, 5, 0, 0));
        add_item(mk_in(slt_pkg::OP_GC, 0, 0, 11));
        add_item(mk_in(slt_pkg::OP_FINISH, 5, 0, 10));
        add_item(mk_in(slt_pkg::OP_GC, 0, 0, 10));
        add_item(mk_in(slt_pkg::OP_GC, 0, 0, '1));
        add_item(mk_in(slt_pkg::OP_HOLDERS, 0, '1, 0));
        add_item(mk_in(slt_pkg::OP_ACQUIRE, '1, '1, 0));
        // fill past capacity while the receiver holds off
        for (int i = 0; i < 66; i++) add_item(mk_in(slt_pkg::OP_ACQUIRE, 9, i, 0));
        hold_rx = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;
        wait (pending_items.size() == 0);
        // pause until every result is back
        drain_pause = 1'b1;
        wait (lock_results.size() == 0 && !i_valid);
        repeat (150) @(posedge i_clk);
        drain_pause = 1'b0;
        for (int i = 0; i < 8; i++) add_item(mk_in(slt_pkg::OP_HOLDERS, 0, i, 0));
        add_item(mk_in(slt_pkg::OP_FINISH, 9, 0, 1));
        add_item(mk_in(slt_pkg::OP_GC, 0, 0, 2));
        // random part, mostly drawn from small pools so records collide
        for (int n = 0; n < 227; n++) begin
            k = $urandom_range(0, 99);
            it.txn_id = ($urandom_range(0, 9) == 0) ? $urandom() : txn_pool[$urandom_range(0, 7)];
            it.page_id = ($urandom_range(0, 9) == 0) ? $urandom() : page_pool[$urandom_range(0, 7)];
            it.time_stamp = ($urandom_range(0, 3) == 0) ? rnd48() : 48'($urandom_range(0, 40));
            if (k < 45) it.opcode = slt_pkg::OP_ACQUIRE;
            else if (k < 75) it.opcode = slt_pkg::OP_HOLDERS;
            else if (k < 92) it.opcode = slt_pkg::OP_FINISH;
            else it.opcode = slt_pkg::OP_GC;
            if (n == 180) calm = 1'b1;
            add_item(it);
        end
        wait (pending_items.size() == 0);
        wait (lock_results.size() == 0 && !i_valid);
        repeat (200) @(posedge i_clk);
        done = 1'b1;
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_cell.sv
rtl/siread_lock_table_top.sv
test/tb_top.sv
